/* hdl/nlej_pkg.sv */
// Shared types and constants for the nested-loop equi-join block.
package nlej_pkg;

  // Number of build rows the table can hold.
  localparam int unsigned BuildDepth = 64;
  // Width of the row counter, which must also hold BuildDepth itself.
  localparam int unsigned CntW = $clog2(BuildDepth + 1);
  // Width of an index into the table.
  localparam int unsigned IdxW = (BuildDepth > 1) ? $clog2(BuildDepth) : 1;
  localparam int unsigned KeyW = 32;
  localparam int unsigned RowW = 32;

  // Command codes carried by the action field.
  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActProbe = 2'd1,
    ActClear = 2'd2
  } action_e;

  // Result codes carried by the status field.
  typedef enum logic [2:0] {
    StLoaded  = 3'd0,
    StFull    = 3'd1,
    StMatch   = 3'd2,
    StNoMatch = 3'd3,
    StCleared = 3'd4
  } status_e;

  // Control from the sequencer to the row of cells.
  typedef struct packed {
    logic            shift;
    logic            load;
    logic [IdxW-1:0] idx;
  } chain_ctrl_t;

endpackage

/* hdl/nested_loop_equi_join_top.sv */
// Top level of the nested-loop equi-join block: sequencer, result register, cell ring.
//
// Usage: an item is taken at a rising edge where start_i is high and busy_o is
// low. action_i selects load (append key_i/row_id_i), probe, or clear; code 3
// is ignored and gives no result. Each result beat appears on status_o,
// build_row_o, probe_row_o and last_o for exactly one cycle with valid_o high;
// the receiver cannot stall, so every beat is taken when shown.
// Load and clear: the single result beat appears the cycle after the item is
// taken, and busy_o stays low, so one such item can be taken every cycle.
// Probe: the stored rows rotate once around the ring of cells, one row per
// cycle past the head cell, so a probe keeps busy_o high through the whole
// rotation and the Finish state, whatever the fill level. Each matching row is
// held back until the next match so the final one can carry last; its beat is
// shown the cycle after the compare of the next matching row. The final beat
// comes in the cycle busy_o falls, and the next item may be taken in that cycle.
// Reset (rst_ni low, asynchronous) empties the table and drops any scan and
// pending beat; cell contents are kept but are unreachable until rewritten.
module nested_loop_equi_join_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        action_i,
  input  logic signed [nlej_pkg::KeyW-1:0]  key_i,
  input  logic        [nlej_pkg::RowW-1:0]  row_id_i,
  output logic                              valid_o,
  output logic [2:0]                        status_o,
  output logic [nlej_pkg::RowW-1:0]         build_row_o,
  output logic [nlej_pkg::RowW-1:0]         probe_row_o,
  output logic                              last_o
);

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Finish
  } state_e;

  localparam logic [nlej_pkg::IdxW-1:0] LastIdx = nlej_pkg::IdxW'(nlej_pkg::BuildDepth - 1);
  localparam logic [nlej_pkg::CntW-1:0] FullCnt = nlej_pkg::CntW'(nlej_pkg::BuildDepth);

  state_e                           state_q;
  logic [nlej_pkg::CntW-1:0]        count_q;
  logic [nlej_pkg::IdxW-1:0]        idx_q;
  logic signed [nlej_pkg::KeyW-1:0] pkey_q;
  logic [nlej_pkg::RowW-1:0]        prow_q;
  logic                             pend_q;
  logic [nlej_pkg::RowW-1:0]        pend_row_q;
  logic                             valid_q;
  nlej_pkg::status_e                status_q;
  logic [nlej_pkg::RowW-1:0]        build_q;
  logic [nlej_pkg::RowW-1:0]        probe_q;
  logic                             last_q;

  nlej_pkg::chain_ctrl_t            ctrl;
  logic signed [nlej_pkg::KeyW-1:0] head_key;
  logic [nlej_pkg::RowW-1:0]        head_row;
  logic                             accept;
  logic                             hit;

  assign busy_o = (state_q != Idle);
  assign accept = start_i && !busy_o;
  // A compare counts only for rows below the fill level.
  assign hit    = (state_q == Scan) && ({1'b0, idx_q} < count_q) &&
                  (head_key == pkey_q);

  // Ring control: rotate during a scan, write a free cell on an accepted load.
  always_comb begin
    ctrl.shift = (state_q == Scan);
    ctrl.load  = accept && (action_i == nlej_pkg::ActLoad) && (count_q != FullCnt);
    ctrl.idx   = count_q[nlej_pkg::IdxW-1:0];
  end

  nlej_chain u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .load_key_i (key_i),
    .load_row_i (row_id_i),
    .head_key_o (head_key),
    .head_row_o (head_row)
  );

  // Control state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Idle;
      count_q    <= '0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      valid_q    <= 1'b0;
      status_q   <= nlej_pkg::StLoaded;
      build_q    <= '0;
      probe_q    <= '0;
      last_q     <= 1'b0;
      pkey_q     <= '0;
      prow_q     <= '0;
      pend_row_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        Idle: begin
          if (accept) begin
            case (nlej_pkg::action_e'(action_i))
              nlej_pkg::ActLoad: begin
                valid_q  <= 1'b1;
                build_q  <= '0;
                probe_q  <= '0;
                last_q   <= 1'b1;
                if (count_q == FullCnt) begin
                  status_q <= nlej_pkg::StFull;
                end else begin
                  status_q <= nlej_pkg::StLoaded;
                  count_q  <= count_q + nlej_pkg::CntW'(1);
                end
              end
              nlej_pkg::ActProbe: begin
                pkey_q  <= key_i;
                prow_q  <= row_id_i;
                idx_q   <= '0;
                pend_q  <= 1'b0;
                state_q <= Scan;
              end
              nlej_pkg::ActClear: begin
                count_q  <= '0;
                valid_q  <= 1'b1;
                status_q <= nlej_pkg::StCleared;
                build_q  <= '0;
                probe_q  <= '0;
                last_q   <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        Scan: begin
          // A new match releases the one held back, which cannot be the last.
          if (hit) begin
            if (pend_q) begin
              valid_q  <= 1'b1;
              status_q <= nlej_pkg::StMatch;
              build_q  <= pend_row_q;
              probe_q  <= prow_q;
              last_q   <= 1'b0;
            end
            pend_q     <= 1'b1;
            pend_row_q <= head_row;
          end
          idx_q <= idx_q + nlej_pkg::IdxW'(1);
          if (idx_q == LastIdx) begin
            state_q <= Finish;
          end
        end
        Finish: begin
          // Final beat: the held match, or a no-match result.
          valid_q  <= 1'b1;
          probe_q  <= prow_q;
          last_q   <= 1'b1;
          if (pend_q) begin
            status_q <= nlej_pkg::StMatch;
            build_q  <= pend_row_q;
          end else begin
            status_q <= nlej_pkg::StNoMatch;
            build_q  <= '0;
          end
          pend_q  <= 1'b0;
          state_q <= Idle;
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign build_row_o = build_q;
  assign probe_row_o = probe_q;
  assign last_o      = last_q;

  // The fill level never exceeds the table depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("row count beyond table depth");

  // An accepted probe makes the block busy in the next cycle.
  a_probe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == nlej_pkg::ActProbe) |=> busy_o)
    else $error("probe did not start a scan");

  // Every scan ends in a final beat.
  a_finish_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Finish) |=> (valid_o && last_o && !busy_o))
    else $error("scan ended without a final beat");

  // Match beats shown while still scanning are never marked last.
  a_mid_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && busy_o) |-> (!last_o && status_o == nlej_pkg::StMatch))
    else $error("beat during scan is not an unmarked match");

  // No row is written while the ring rotates.
  a_no_load_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift |-> !ctrl.load)
    else $error("load during rotation");

endmodule

/* hdl/nlej_cell.sv */
// One table cell: holds a key and a row id, loads or takes its neighbor's row.
module nlej_cell (
  input  logic                              clk_i,
  input  logic                              shift_i,
  input  logic                              load_i,
  input  logic signed [nlej_pkg::KeyW-1:0]  load_key_i,
  input  logic        [nlej_pkg::RowW-1:0]  load_row_i,
  input  logic signed [nlej_pkg::KeyW-1:0]  nbr_key_i,
  input  logic        [nlej_pkg::RowW-1:0]  nbr_row_i,
  output logic signed [nlej_pkg::KeyW-1:0]  key_o,
  output logic        [nlej_pkg::RowW-1:0]  row_o
);

  logic signed [nlej_pkg::KeyW-1:0] key_q, key_d;
  logic        [nlej_pkg::RowW-1:0] row_q, row_d;

  // A shift moves the neighbor's row in; otherwise a load writes this cell.
  always_comb begin
    key_d = key_q;
    row_d = row_q;
    if (shift_i) begin
      key_d = nbr_key_i;
      row_d = nbr_row_i;
    end else if (load_i) begin
      key_d = load_key_i;
      row_d = load_row_i;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    row_q <= row_d;
  end

  assign key_o = key_q;
  assign row_o = row_q;

endmodule

/* hdl/nlej_chain.sv */
// Ring of table cells; the head cell is the one the scan compares.
module nlej_chain (
  input  logic                              clk_i,
  input  nlej_pkg::chain_ctrl_t             ctrl_i,
  input  logic signed [nlej_pkg::KeyW-1:0]  load_key_i,
  input  logic        [nlej_pkg::RowW-1:0]  load_row_i,
  output logic signed [nlej_pkg::KeyW-1:0]  head_key_o,
  output logic        [nlej_pkg::RowW-1:0]  head_row_o
);

  logic signed [nlej_pkg::KeyW-1:0] cell_key [nlej_pkg::BuildDepth];
  logic        [nlej_pkg::RowW-1:0] cell_row [nlej_pkg::BuildDepth];

  // Each cell takes the row of the next one; the last wraps to the head.
  for (genvar i = 0; i < nlej_pkg::BuildDepth; i++) begin : g_cell
    localparam int unsigned Nbr = (i + 1) % nlej_pkg::BuildDepth;
    logic sel;
    assign sel = ctrl_i.load && (ctrl_i.idx == nlej_pkg::IdxW'(i));

    nlej_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctrl_i.shift),
      .load_i     (sel),
      .load_key_i (load_key_i),
      .load_row_i (load_row_i),
      .nbr_key_i  (cell_key[Nbr]),
      .nbr_row_i  (cell_row[Nbr]),
      .key_o      (cell_key[i]),
      .row_o      (cell_row[i])
    );
  end

  assign head_key_o = cell_key[0];
  assign head_row_o = cell_row[0];

endmodule
